>>> hw/rtl/ignition_dwell_correction_unit_assert.svh
// Assertion macros used by the dwell correction port checker
`ifndef IGNITION_DWELL_CORRECTION_UNIT_ASSERT_SVH
`define IGNITION_DWELL_CORRECTION_UNIT_ASSERT_SVH

// implication in the same cycle, masked while reset is asserted
`define IDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication into the following cycle, masked while reset is asserted
`define IDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// implication into the following cycle, checked through reset as well
`define IDC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/idc_pkg.sv
// Types and constants of the ignition dwell correction unit
package idc_pkg;

    localparam int unsigned QUO_W   = 24;
    localparam int unsigned DIV_A_W = 21;
    localparam int unsigned DIV_B_W = 4;
    localparam int unsigned NUM_W   = 39;
    localparam int unsigned CELLS   = QUO_W;

    // floor(x / 100) for 16-bit x as (x * RECIP_100) >> RECIP_SHIFT
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam int unsigned RECIP_SHIFT = 23;

    localparam logic [7:0]  PCT_UNITY   = 8'd100;
    localparam logic [14:0] SPARK_SCALE = 15'd100;
    localparam logic [15:0] DWELL_MAX   = 16'hFFFF;
    localparam logic [15:0] HALF_CAP    = 16'd32767;

    localparam logic [7:0] SPARK_DURATION_RST = 8'd10;
    localparam logic       ERR_CORR_EN_RST    = 1'b0;
    localparam logic [4:0] CYLINDER_COUNT_RST = 5'd4;
    localparam logic       MULTI_PULSE_RST    = 1'b0;

    typedef enum logic [1:0] {
        REG_SPARK_DURATION,
        REG_ERROR_CORRECT_ENABLE,
        REG_CYLINDER_COUNT,
        REG_MULTI_PULSE_MODE
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] spark_duration;
        logic       error_correct_enable;
        logic [4:0] cylinder_count;
        logic       multi_pulse_mode;
    } t_cfg;

    // one slot of the divider chain: burn division (a) and share division (b)
    typedef struct packed {
        logic               valid;
        logic               limit;
        logic [15:0]        target;
        logic [DIV_A_W-1:0] rem_a;
        logic [QUO_W-1:0]   quo_a;
        logic [DIV_A_W-1:0] div_a;
        logic [DIV_B_W-1:0] rem_b;
        logic [QUO_W-1:0]   quo_b;
        logic [DIV_B_W-1:0] div_b;
    } t_cell;

endpackage

>>> hw/rtl/ignition_dwell_correction_unit.sv
// Top level of the ignition dwell correction unit with its register port
// Takes one transaction per clock while o_stall is low and passes it on through the
// pipeline: four front stages (voltage scaling, error correction, limiter operands),
// then a row of 24 division cells, each of which resolves one quotient
// bit of the spark-burn share and of the per-pulse revolution share, and a final
// output register. The pipeline holds while a finished result waits under o_stall's
// counterpart i_stall, so o_stall is high only when the output register is full and
// stalled. Registers are written through the APB port at byte offsets 0, 4, 8 and 12
// and should only be changed while no transaction is in flight. No memories and no
// clearing pass after reset.
module ignition_dwell_correction_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_base_dwell,
    input  logic [7:0]  i_voltage_correction,
    input  logic [15:0] i_measured_dwell,
    input  logic [23:0] i_revolution_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_corrected_dwell,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import idc_pkg::*;

    t_cfg        r_cfg;
    logic        adv;
    logic        cfg_wr;
    t_reg_idx    reg_idx;
    t_cell       chain [0:CELLS];
    logic        r_out_valid;
    logic [15:0] r_out_dwell;
    logic [15:0] n_out_dwell;
    logic [QUO_W-1:0] share_diff;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spark_duration       <= SPARK_DURATION_RST;
            r_cfg.error_correct_enable <= ERR_CORR_EN_RST;
            r_cfg.cylinder_count       <= CYLINDER_COUNT_RST;
            r_cfg.multi_pulse_mode     <= MULTI_PULSE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SPARK_DURATION:       r_cfg.spark_duration       <= pwdata[7:0];
                REG_ERROR_CORRECT_ENABLE: r_cfg.error_correct_enable <= pwdata[0];
                REG_CYLINDER_COUNT:       r_cfg.cylinder_count       <= pwdata[4:0];
                REG_MULTI_PULSE_MODE:     r_cfg.multi_pulse_mode     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SPARK_DURATION:       prdata = 32'(r_cfg.spark_duration);
            REG_ERROR_CORRECT_ENABLE: prdata = 32'(r_cfg.error_correct_enable);
            REG_CYLINDER_COUNT:       prdata = 32'(r_cfg.cylinder_count);
            REG_MULTI_PULSE_MODE:     prdata = 32'(r_cfg.multi_pulse_mode);
            default:                  prdata = '0;
        endcase
    end

    // advance the whole pipeline unless a finished result is stalled
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    idc_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_adv                (adv),
        .i_valid              (i_valid),
        .i_base_dwell         (i_base_dwell),
        .i_voltage_correction (i_voltage_correction),
        .i_measured_dwell     (i_measured_dwell),
        .i_revolution_time    (i_revolution_time),
        .i_cfg                (r_cfg),
        .o_cell               (chain[0])
    );

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        idc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cell  (chain[k]),
            .o_cell  (chain[k+1])
        );
    end

    // quo_a holds the spark burn share, quo_b the per-pulse revolution share
    assign share_diff = chain[CELLS].quo_b - chain[CELLS].quo_a;

    always_comb begin
        if (!chain[CELLS].limit) begin
            n_out_dwell = chain[CELLS].target;
        end else if (chain[CELLS].quo_a >= chain[CELLS].quo_b) begin
            n_out_dwell = '0;
        end else if (share_diff > QUO_W'(DWELL_MAX)) begin
            n_out_dwell = DWELL_MAX;
        end else begin
            n_out_dwell = share_diff[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= chain[CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_dwell <= n_out_dwell;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_corrected_dwell = r_out_dwell;

endmodule

>>> hw/rtl/idc_front.sv
// Front pipeline: voltage correction, error correction and limiter operands
module idc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  logic [15:0]    i_base_dwell,
    input  logic [7:0]     i_voltage_correction,
    input  logic [15:0]    i_measured_dwell,
    input  logic [23:0]    i_revolution_time,
    input  idc_pkg::t_cfg  i_cfg,
    output idc_pkg::t_cell o_cell
);
    import idc_pkg::*;

    // stage A
    logic        r_a_valid;
    logic [15:0] r_a_base;
    logic [7:0]  r_a_pct;
    logic [15:0] r_a_meas;
    logic [23:0] r_a_rev;
    logic [9:0]  r_a_q100;
    logic [32:0] n_a_recip;

    // stage B
    logic        r_b_valid;
    logic [15:0] r_b_target;
    logic [15:0] r_b_actual;
    logic [23:0] r_b_rev;
    logic [17:0] n_b_scaled;
    logic [15:0] n_b_target;
    logic [15:0] n_b_actual;

    // stage C
    logic        r_c_valid;
    logic [15:0] r_c_target;
    logic [23:0] r_c_rev;
    logic [15:0] n_c_short;
    logic [13:0] n_c_half;
    logic [16:0] n_c_add;
    logic [17:0] n_c_sum;
    logic [15:0] n_c_target;

    // stage D
    logic               r_d_valid;
    logic [15:0]        r_d_target;
    logic [23:0]        r_d_rev;
    logic [DIV_A_W-1:0] r_d_per_rev;
    logic [NUM_W-1:0]   r_d_burn_num;
    logic [DIV_B_W-1:0] r_d_pulses;
    logic [14:0]        n_d_spark;
    logic [16:0]        n_d_sum;
    logic [DIV_B_W-1:0] n_d_pulses;
    logic [DIV_A_W-1:0] n_d_per_rev;
    logic [NUM_W-1:0]   n_d_burn_num;

    assign n_a_recip = 33'(i_base_dwell) * 33'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_base <= i_base_dwell;
            r_a_pct  <= i_voltage_correction;
            r_a_meas <= i_measured_dwell;
            r_a_rev  <= i_revolution_time;
            r_a_q100 <= n_a_recip[32:RECIP_SHIFT];
        end
    end

    assign n_b_scaled = 18'(r_a_q100) * 18'(r_a_pct);

    always_comb begin
        if (r_a_pct == PCT_UNITY) begin
            n_b_target = r_a_base;
        end else if (n_b_scaled > 18'(DWELL_MAX)) begin
            n_b_target = DWELL_MAX;
        end else begin
            n_b_target = n_b_scaled[15:0];
        end
        n_b_actual = (r_a_meas == 16'd0) ? r_a_base : r_a_meas;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_target <= n_b_target;
            r_b_actual <= n_b_actual;
            r_b_rev    <= r_a_rev;
        end
    end

    // add the shortfall, doubled when it is more than half the capped target
    always_comb begin
        n_c_short = r_b_target - r_b_actual;
        n_c_half  = (r_b_target > HALF_CAP) ? HALF_CAP[14:1] : r_b_target[14:1];
        n_c_add   = (n_c_short > 16'(n_c_half)) ? {n_c_short, 1'b0} : {1'b0, n_c_short};
        n_c_sum   = 18'(r_b_target) + 18'(n_c_add);
        if (!i_cfg.error_correct_enable || r_b_target <= r_b_actual) begin
            n_c_target = r_b_target;
        end else if (n_c_sum > 18'(DWELL_MAX)) begin
            n_c_target = DWELL_MAX;
        end else begin
            n_c_target = n_c_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_target <= n_c_target;
            r_c_rev    <= r_b_rev;
        end
    end

    always_comb begin
        n_d_spark = 15'(i_cfg.spark_duration) * SPARK_SCALE;
        n_d_sum   = 17'(r_c_target) + 17'(n_d_spark);
        if (i_cfg.cylinder_count <= 5'd1 || !i_cfg.multi_pulse_mode) begin
            n_d_pulses = DIV_B_W'(1);
        end else begin
            n_d_pulses = i_cfg.cylinder_count[4:1];
        end
        n_d_per_rev  = DIV_A_W'(n_d_sum) * DIV_A_W'(n_d_pulses);
        n_d_burn_num = NUM_W'(n_d_spark) * NUM_W'(r_c_rev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_target   <= r_c_target;
            r_d_rev      <= r_c_rev;
            r_d_per_rev  <= n_d_per_rev;
            r_d_burn_num <= n_d_burn_num;
            r_d_pulses   <= n_d_pulses;
        end
    end

    // load the head of the divider chain; the burn quotient fits 24 bits whenever limiting
    always_comb begin
        o_cell.valid  = r_d_valid;
        o_cell.limit  = 24'(r_d_per_rev) > r_d_rev;
        o_cell.target = r_d_target;
        o_cell.rem_a  = DIV_A_W'(r_d_burn_num[NUM_W-1:QUO_W]);
        o_cell.quo_a  = r_d_burn_num[QUO_W-1:0];
        o_cell.div_a  = r_d_per_rev;
        o_cell.rem_b  = '0;
        o_cell.quo_b  = r_d_rev;
        o_cell.div_b  = r_d_pulses;
    end

endmodule

>>> hw/rtl/idc_div_cell.sv
// One restoring-division cell: resolves one quotient bit of both divisions
module idc_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  idc_pkg::t_cell i_cell,
    output idc_pkg::t_cell o_cell
);
    import idc_pkg::*;

    logic [DIV_A_W:0] a_part;
    logic [DIV_A_W:0] a_diff;
    logic             a_fit;
    logic [DIV_B_W:0] b_part;
    logic [DIV_B_W:0] b_diff;
    logic             b_fit;
    t_cell            n_cell;
    t_cell            r_cell;

    // shift the next dividend bit out of the quotient word into the remainder
    assign a_part = {i_cell.rem_a, i_cell.quo_a[QUO_W-1]};
    assign a_diff = a_part - {1'b0, i_cell.div_a};
    assign a_fit  = a_part >= {1'b0, i_cell.div_a};

    assign b_part = {i_cell.rem_b, i_cell.quo_b[QUO_W-1]};
    assign b_diff = b_part - {1'b0, i_cell.div_b};
    assign b_fit  = b_part >= {1'b0, i_cell.div_b};

    always_comb begin
        n_cell       = i_cell;
        n_cell.rem_a = a_fit ? a_diff[DIV_A_W-1:0] : a_part[DIV_A_W-1:0];
        n_cell.quo_a = {i_cell.quo_a[QUO_W-2:0], a_fit};
        n_cell.rem_b = b_fit ? b_diff[DIV_B_W-1:0] : b_part[DIV_B_W-1:0];
        n_cell.quo_b = {i_cell.quo_b[QUO_W-2:0], b_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> hw/rtl/idc_checker.sv
// Port-level checker for the ignition dwell correction unit, bound to the top level
`include "ignition_dwell_correction_unit_assert.svh"

module idc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_corrected_dwell,
    input logic        psel,
    input logic        penable,
    input logic        pready
);

    // input side backs up only behind a stalled result
    `IDC_ASSERT_SAME(a_stall_backlog, i_clk, i_rst_n, o_stall, o_valid && i_stall, "o_stall without a stalled result")

    // a stalled result stays put
    `IDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_corrected_dwell), "stalled result changed")

    // reset empties the output
    `IDC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid && !o_stall, "output not empty after reset")

    // a pending result never blocks a register access
    `IDC_ASSERT_SAME(a_pready_high, i_clk, i_rst_n, psel && penable, pready, "register access held off")

endmodule

bind ignition_dwell_correction_unit idc_checker u_idc_checker (.*);

>>> tb/sv/idc_dwell_checker.sv
// Checker for the dwell correction unit: predicts each corrected dwell and compares results
module idc_dwell_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [15:0] i_base_dwell,
    input  logic [7:0]  i_voltage_correction,
    input  logic [15:0] i_measured_dwell,
    input  logic [23:0] i_revolution_time,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_corrected_dwell,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_outstanding,
    output int          o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import idc_pkg::*;

    t_cfg        cfg;
    logic [15:0] dwell_q[$];
    int          mismatch_count = 0;

    function automatic logic [63:0] sat_dwell(logic [63:0] v);
        return (v > 64'(DWELL_MAX)) ? 64'(DWELL_MAX) : v;
    endfunction

    function automatic logic [15:0] corrected_dwell_for(logic [15:0] base, logic [7:0] pct,
            logic [15:0] measured, logic [23:0] rev);
        logic [63:0] spark_us, target, actual, pulses, per_rev, burn, share;
        longint      shortfall, half_cap;
        spark_us = 64'(cfg.spark_duration) * 64'(SPARK_SCALE);
        if (pct == PCT_UNITY) begin
            target = 64'(base);
        end else begin
            target = sat_dwell((64'(base) / 64'd100) * 64'(pct));
        end
        if (cfg.error_correct_enable) begin
            actual = (measured == 16'd0) ? 64'(base) : 64'(measured);
            shortfall = longint'(target) - longint'(actual);
            half_cap = (target > 64'(HALF_CAP)) ? longint'(HALF_CAP) : longint'(target);
            half_cap = half_cap / 2;
            // double a shortfall beyond half the capped target
            if (shortfall > half_cap) begin
                shortfall = shortfall * 2;
            end
            if (shortfall > 0) begin
                target = sat_dwell(target + 64'(shortfall));
            end
        end
        if (cfg.cylinder_count <= 5'd1 || !cfg.multi_pulse_mode) begin
            pulses = 64'd1;
        end else begin
            pulses = 64'(cfg.cylinder_count >> 1);
        end
        per_rev = (target + spark_us) * pulses;
        if (per_rev <= 64'(rev)) begin
            return target[15:0];
        end
        // scale dwell and spark down to fit one revolution
        burn  = (spark_us * 64'(rev)) / per_rev;
        share = 64'(rev) / pulses;
        if (burn >= share) begin
            return 16'd0;
        end
        share = sat_dwell(share - burn);
        return share[15:0];
    endfunction

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            cfg.spark_duration       = SPARK_DURATION_RST;
            cfg.error_correct_enable = ERR_CORR_EN_RST;
            cfg.cylinder_count       = CYLINDER_COUNT_RST;
            cfg.multi_pulse_mode     = MULTI_PULSE_RST;
            dwell_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_SPARK_DURATION:       cfg.spark_duration       = i_pwdata[7:0];
                    REG_ERROR_CORRECT_ENABLE: cfg.error_correct_enable = i_pwdata[0];
                    REG_CYLINDER_COUNT:       cfg.cylinder_count       = i_pwdata[4:0];
                    REG_MULTI_PULSE_MODE:     cfg.multi_pulse_mode     = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                dwell_q.push_back(corrected_dwell_for(i_base_dwell, i_voltage_correction,
                                                      i_measured_dwell, i_revolution_time));
            end
            if (i_out_valid && !i_out_stall) begin
                if (dwell_q.size() == 0) begin
                    $display("%t unexpected transaction: expected none, got %0d",
                             $time, i_corrected_dwell);
                    mismatch_count++;
                end else begin
                    want = dwell_q.pop_front();
                    if (want !== i_corrected_dwell) begin
                        $display("%t corrected_dwell mismatch: expected %0d, got %0d",
                                 $time, want, i_corrected_dwell);
                        mismatch_count++;
                    end
                end
            end
        end
        o_outstanding <= dwell_q.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

>>> tb/sv/ignition_dwell_correction_unit_test.sv
// Testbench top for the dwell correction unit: stimulus, register setup and verdict
module ignition_dwell_correction_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import idc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    logic        i_clk                = 1'b0;
    logic        i_rst_n              = 1'b0;
    logic        i_valid              = 1'b0;
    logic        o_stall;
    logic [15:0] i_base_dwell         = '0;
    logic [7:0]  i_voltage_correction = '0;
    logic [15:0] i_measured_dwell     = '0;
    logic [23:0] i_revolution_time    = '0;
    logic        o_valid;
    logic        i_stall              = 1'b0;
    logic [15:0] o_corrected_dwell;
    logic        psel                 = 1'b0;
    logic        penable              = 1'b0;
    logic        pwrite               = 1'b0;
    logic [3:0]  paddr                = '0;
    logic [31:0] pwdata               = '0;
    logic [31:0] prdata;
    logic        pready;

    int outstanding;
    int mismatches;
    int quiet_cycles = 0;
    bit calm         = 1'b0;
    bit steady       = 1'b0;
    bit hold_req     = 1'b0;

    always #5 i_clk = ~i_clk;

    ignition_dwell_correction_unit i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_base_dwell         (i_base_dwell),
        .i_voltage_correction (i_voltage_correction),
        .i_measured_dwell     (i_measured_dwell),
        .i_revolution_time    (i_revolution_time),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_corrected_dwell    (o_corrected_dwell),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    idc_dwell_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_valid),
        .i_in_stall           (o_stall),
        .i_base_dwell         (i_base_dwell),
        .i_voltage_correction (i_voltage_correction),
        .i_measured_dwell     (i_measured_dwell),
        .i_revolution_time    (i_revolution_time),
        .i_out_valid          (o_valid),
        .i_out_stall          (i_stall),
        .i_corrected_dwell    (o_corrected_dwell),
        .i_psel               (psel),
        .i_penable            (penable),
        .i_pwrite             (pwrite),
        .i_pready             (pready),
        .i_paddr              (paddr),
        .i_pwdata             (pwdata),
        .o_outstanding        (outstanding),
        .o_mismatches         (mismatches)
    );

    // end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** ignition_dwell_correction_unit: FAILED **");
            $finish;
        end
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // back-pressure long enough to fill the pipeline
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(logic [15:0] base, logic [7:0] pct, logic [15:0] measured,
            logic [23:0] rev);
        i_valid              <= 1'b1;
        i_base_dwell         <= base;
        i_voltage_correction <= pct;
        i_measured_dwell     <= measured;
        i_revolution_time    <= rev;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!calm && !steady && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        logic [15:0] base, measured;
        logic [7:0]  pct;
        logic [23:0] rev;
        case ($urandom_range(0, 3))
            0:       base = 16'($urandom_range(0, 8000));
            1:       base = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 655) * 100);
            default: base = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       pct = PCT_UNITY;
            1:       pct = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: pct = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       measured = 16'd0;
            1:       measured = base + 16'($urandom_range(0, 2000)) - 16'd1000;
            2:       measured = base >> 1;
            default: measured = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       rev = 24'($urandom_range(0, 20000));
            1:       rev = 24'($urandom_range(0, 300000));
            2:       rev = 24'($urandom_range(0, 1000));
            3:       rev = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
            default: rev = 24'($urandom);
        endcase
        send_item(base, pct, measured, rev);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold until every transaction in flight has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic apply_settings(logic [31:0] spark, logic [31:0] err_en, logic [31:0] cyl,
            logic [31:0] multi);
        wait_drained();
        write_reg(REG_SPARK_DURATION, spark);
        write_reg(REG_ERROR_CORRECT_ENABLE, err_en);
        write_reg(REG_CYLINDER_COUNT, cyl);
        write_reg(REG_MULTI_PULSE_MODE, multi);
    endtask

    initial begin : stimulus
        int phase;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // values after reset: 1 ms spark, one pulse per revolution
        send_item(16'd0,     8'd0,   16'd0, 24'd0);
        send_item(16'hFFFF,  8'd100, 16'd0, 24'hFFFFFF);
        send_item(16'hFFFF,  8'd255, 16'd0, 24'hFFFFFF);
        send_item(16'd5000,  8'd99,  16'd0, 24'd3000);
        send_item(16'd1234,  8'd101, 16'd0, 24'd100000);

        // zero cylinders, no spark, error correction on
        apply_settings(32'd0, 32'd1, 32'd0, 32'd1);
        send_item(16'd0,     8'd100, 16'd0,     24'd0);
        send_item(16'd4000,  8'd100, 16'd1000,  24'hFFFFFF);
        send_item(16'd4000,  8'd100, 16'd3000,  24'hFFFFFF);
        send_item(16'd4000,  8'd100, 16'd5000,  24'hFFFFFF);
        send_item(16'd60000, 8'd100, 16'd1,     24'hFFFFFF);
        send_item(16'd4000,  8'd50,  16'd0,     24'hFFFFFF);
        send_item(16'd40000, 8'd100, 16'd20000, 24'hFFFFFF);

        // longest spark, eight pulses
        apply_settings(32'd255, 32'd1, 32'd16, 32'd1);
        send_item(16'hFFFF,  8'd255, 16'hFFFF, 24'hFFFFFF);
        send_item(16'd3000,  8'd100, 16'd0,    24'd50000);
        send_item(16'd0,     8'd0,   16'd0,    24'd1);
        send_item(16'd0,     8'd0,   16'd0,    24'd0);

        apply_settings(32'd1, 32'd0, 32'd31, 32'd1);
        send_item(16'hFFFF,  8'd100, 16'd0,    24'hFFFFFF);
        send_item(16'd1000,  8'd200, 16'd0,    24'd20000);
        send_item(16'd100,   8'd255, 16'hFFFF, 24'd12345);

        apply_settings(32'd255, 32'd0, 32'd1, 32'd1);
        send_item(16'hFFFF,  8'd100, 16'd0,    24'd65535);
        send_item(16'hFFFF,  8'd100, 16'd0,    24'd91035);

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                1:       apply_settings(32'd0, 32'd1, 32'd0, 32'd1);
                2:       apply_settings(32'd255, 32'd1, 32'd31, 32'd1);
                3:       apply_settings(32'd255, 32'd0, 32'd16, 32'd1);
                7:       apply_settings($urandom_range(0, 255), $urandom_range(0, 1),
                                        $urandom_range(1, 16), 32'd1);
                default: apply_settings($urandom, $urandom, $urandom, $urandom);
            endcase
            if (phase == 0) begin
                // keep offering while the output is held off
                hold_req = 1'b1;
                steady   = 1'b1;
                repeat (60) send_random();
                steady   = 1'b0;
            end
            if (phase == 7) begin
                calm = 1'b1;
            end
            repeat (80) send_random();
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** ignition_dwell_correction_unit: PASSED **");
        end else begin
            $display("** ignition_dwell_correction_unit: FAILED **");
        end
        $finish;
    end

endmodule
